// ----- rtl/core/lmsf_pkg.sv -----
// ----------------------------------------------------------------------------
// lmsf_pkg: shared definitions for the LMS adaptive FIR filter
// Register indexes, reset values, fixed field widths and the control structs
// that pass between the sequencer, the store and the multiply unit.
// ----------------------------------------------------------------------------
`default_nettype none

package lmsf_pkg;

    localparam int MAX_TAPS_DEF    = 128;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int TAP_CNT_W   = 8;
    localparam int STEP_W      = 6;
    localparam int INIT_W      = 31;
    localparam int WEIGHT_W    = 32;
    localparam int WEIGHT_FRAC = 30;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;

    localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_SHIFT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_WEIGHT = 2'd2;

    localparam logic [TAP_CNT_W-1:0] TAP_COUNT_RST   = 8'd32;
    localparam logic [STEP_W-1:0]    STEP_SHIFT_RST  = 6'd29;
    localparam logic [INIT_W-1:0]    INIT_WEIGHT_RST = 31'd33554432;

    // One tap request into the shared multiplier pipeline.
    typedef struct packed {
        logic issue;
        logic upd;
    } lmsf_op_t;

    typedef struct packed {
        logic clr_acc;
        logic latch_err;
    } lmsf_mac_ctl_t;

    typedef struct packed {
        logic win_we;
        logic trace_start;
    } lmsf_store_ctl_t;

    typedef struct packed {
        logic done;
        logic vld;
        logic last;
    } lmsf_res_t;

endpackage

`default_nettype wire

// ----- rtl/core/lms_adaptive_fir_filter.sv -----
// ----------------------------------------------------------------------------
// lms_adaptive_fir_filter: adaptive FIR filter with LMS weight update
// One trace sample in, one filtered result out, weights adapted per sample with a valid output.
//
//   Channel  Direction  Ports                     Contents
//   s_       in         tvalid tready tdata tlast  sample, end of trace
//   m_       out        tvalid tready tdata tuser  filtered, valid flag,
//                       tlast                      end of trace
//   cfg_     in         wr_en index wdata          tap_count, step_shift,
//                                                  initial_weight
//
// A sample that gives no valid output skips the tap walks. For a valid one
// the single shared multiplier walks the N taps in use once for the sum and
// once for the update, each walk followed by a pipeline drain. Reset is
// synchronous and needs no clearing pass. A result waits in the output
// register while the next request is taken; the sequencer holds only if a
// second result is ready before the first is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module lms_adaptive_fir_filter #(
    parameter int MAX_TAPS    = lmsf_pkg::MAX_TAPS_DEF,
    parameter int SAMPLE_BITS = lmsf_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    // [SAMPLE_BITS-1:0] sample, zero padding above
    input  wire logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] s_tdata,
    input  wire logic                                 s_tlast,
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // [SAMPLE_BITS-1:0] filtered, zero padding above
    output logic [((SAMPLE_BITS + 7) / 8) * 8-1:0]    m_tdata,
    // [0] valid_res
    output logic                                      m_tuser,
    output logic                                      m_tlast,
    input  wire logic                                 cfg_wr_en,
    input  wire logic [lmsf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [lmsf_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

    localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int PTR_W   = $clog2(MAX_TAPS);

    logic [lmsf_pkg::TAP_CNT_W-1:0] tap_count_reg;
    logic [lmsf_pkg::STEP_W-1:0]    step_shift_reg;
    logic [lmsf_pkg::INIT_W-1:0]    init_weight_reg;

    logic                           m_tvalid_reg;
    logic [TDATA_W-1:0]             m_tdata_reg;
    logic                           m_tuser_reg;
    logic                           m_tlast_reg;

    logic                           out_free;
    logic signed [SAMPLE_BITS-1:0]  s_sample;
    logic [SAMPLE_BITS-1:0]         out_filt;

    lmsf_pkg::lmsf_store_ctl_t      store_ctl;
    lmsf_pkg::lmsf_mac_ctl_t        mac_ctl;
    lmsf_pkg::lmsf_op_t             op;
    lmsf_pkg::lmsf_res_t            res;
    logic [PTR_W-1:0]               win_waddr;
    logic [PTR_W-1:0]               rd_pos;
    logic [PTR_W-1:0]               rd_tap;
    logic signed [SAMPLE_BITS-1:0]  win_rd;
    logic signed [lmsf_pkg::WEIGHT_W-1:0] wt_rd;
    logic                           wb_we;
    logic [PTR_W-1:0]               wb_addr;
    logic signed [lmsf_pkg::WEIGHT_W-1:0] wb_data;
    logic signed [SAMPLE_BITS-1:0]  filtered;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tap_count_reg   <= lmsf_pkg::TAP_COUNT_RST;
            step_shift_reg  <= lmsf_pkg::STEP_SHIFT_RST;
            init_weight_reg <= lmsf_pkg::INIT_WEIGHT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                lmsf_pkg::REG_TAP_COUNT: begin
                    tap_count_reg <= cfg_wdata[lmsf_pkg::TAP_CNT_W-1:0];
                end
                lmsf_pkg::REG_STEP_SHIFT: begin
                    step_shift_reg <= cfg_wdata[lmsf_pkg::STEP_W-1:0];
                end
                lmsf_pkg::REG_INIT_WEIGHT: begin
                    init_weight_reg <= cfg_wdata[lmsf_pkg::INIT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign s_sample = $signed(s_tdata[SAMPLE_BITS-1:0]);
    assign out_free = !m_tvalid_reg || m_tready;

    lmsf_seq #(
        .MAX_TAPS (MAX_TAPS)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_last   (s_tlast),
        .tap_count (tap_count_reg),
        .out_free  (out_free),
        .in_ready  (s_tready),
        .store_ctl (store_ctl),
        .mac_ctl   (mac_ctl),
        .op        (op),
        .win_waddr (win_waddr),
        .rd_pos    (rd_pos),
        .rd_tap    (rd_tap),
        .res       (res)
    );

    lmsf_store #(
        .MAX_TAPS    (MAX_TAPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_store (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl         (store_ctl),
        .win_waddr   (win_waddr),
        .win_wdata   (s_sample),
        .init_weight (init_weight_reg),
        .rd_pos      (rd_pos),
        .rd_tap      (rd_tap),
        .wb_we       (wb_we),
        .wb_addr     (wb_addr),
        .wb_data     (wb_data),
        .win_rd      (win_rd),
        .wt_rd       (wt_rd)
    );

    lmsf_mac #(
        .MAX_TAPS    (MAX_TAPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mac (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (mac_ctl),
        .op         (op),
        .op_tap     (rd_tap),
        .sample     (s_sample),
        .step_shift (step_shift_reg),
        .win_rd     (win_rd),
        .wt_rd      (wt_rd),
        .wb_we      (wb_we),
        .wb_addr    (wb_addr),
        .wb_data    (wb_data),
        .filtered   (filtered)
    );

    // An item without a valid output reports zero.
    assign out_filt = res.vld ? filtered : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res.done) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res.done) begin
            m_tdata_reg <= TDATA_W'(out_filt);
            m_tuser_reg <= res.vld;
            m_tlast_reg <= res.last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    a_invalid_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("result without valid flag carries a non-zero output");

endmodule

`default_nettype wire

// ----- rtl/core/lmsf_store.sv -----
// ----------------------------------------------------------------------------
// lmsf_store: sample window and tap weight memories
// Both memories have one write and one registered read port. Weights carry a
// written flag per tap; an unwritten tap reads as the weight latched at the
// start of the trace, so no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module lmsf_store #(
    parameter int MAX_TAPS    = lmsf_pkg::MAX_TAPS_DEF,
    parameter int SAMPLE_BITS = lmsf_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire lmsf_pkg::lmsf_store_ctl_t              ctl,
    input  wire logic [$clog2(MAX_TAPS)-1:0]            win_waddr,
    input  wire logic signed [SAMPLE_BITS-1:0]          win_wdata,
    input  wire logic [lmsf_pkg::INIT_W-1:0]            init_weight,
    input  wire logic [$clog2(MAX_TAPS)-1:0]            rd_pos,
    input  wire logic [$clog2(MAX_TAPS)-1:0]            rd_tap,
    input  wire logic                                   wb_we,
    input  wire logic [$clog2(MAX_TAPS)-1:0]            wb_addr,
    input  wire logic signed [lmsf_pkg::WEIGHT_W-1:0]   wb_data,
    output logic signed [SAMPLE_BITS-1:0]               win_rd,
    output logic signed [lmsf_pkg::WEIGHT_W-1:0]        wt_rd
);

    logic signed [SAMPLE_BITS-1:0]         win_mem [MAX_TAPS];
    logic signed [lmsf_pkg::WEIGHT_W-1:0]  wt_mem  [MAX_TAPS];

    logic [MAX_TAPS-1:0]                   wt_vld_reg;
    logic [MAX_TAPS-1:0]                   wt_vld_next;
    logic                                  vld_rd_reg;
    logic signed [SAMPLE_BITS-1:0]         win_rd_reg;
    logic signed [lmsf_pkg::WEIGHT_W-1:0]  wt_rd_reg;
    logic [lmsf_pkg::INIT_W-1:0]           init_reg;

    always_ff @(posedge aclk) begin
        if (ctl.win_we) begin
            win_mem[win_waddr] <= win_wdata;
        end
        win_rd_reg <= win_mem[rd_pos];
    end

    always_ff @(posedge aclk) begin
        if (wb_we) begin
            wt_mem[wb_addr] <= wb_data;
        end
        wt_rd_reg <= wt_mem[rd_tap];
    end

    always_comb begin
        wt_vld_next = wt_vld_reg;
        if (ctl.trace_start) begin
            wt_vld_next = '0;
        end else if (wb_we) begin
            wt_vld_next[wb_addr] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wt_vld_reg <= '0;
        end else begin
            wt_vld_reg <= wt_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        vld_rd_reg <= wt_vld_reg[rd_tap];
        if (ctl.trace_start) begin
            init_reg <= init_weight;
        end
    end

    assign win_rd = win_rd_reg;
    assign wt_rd  = vld_rd_reg ? wt_rd_reg : {1'b0, init_reg};

    // A write-back landing on the same edge as the start-of-trace clear would
    // leave a stale tap marked as written.
    a_no_wb_at_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.trace_start |-> !wb_we)
        else $error("weight write-back coincides with start-of-trace clear");

endmodule

`default_nettype wire

// ----- rtl/core/lmsf_mac.sv -----
// ----------------------------------------------------------------------------
// lmsf_mac: shared multiplier with accumulator and weight update
// One signed multiplier serves both passes. In the filter pass the products
// are summed; in the update pass the product is shifted, added to the weight
// and saturated, then written back to the store.
// ----------------------------------------------------------------------------
`default_nettype none

module lmsf_mac #(
    parameter int MAX_TAPS    = lmsf_pkg::MAX_TAPS_DEF,
    parameter int SAMPLE_BITS = lmsf_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire lmsf_pkg::lmsf_mac_ctl_t                ctl,
    input  wire lmsf_pkg::lmsf_op_t                     op,
    input  wire logic [$clog2(MAX_TAPS)-1:0]            op_tap,
    input  wire logic signed [SAMPLE_BITS-1:0]          sample,
    input  wire logic [lmsf_pkg::STEP_W-1:0]            step_shift,
    input  wire logic signed [SAMPLE_BITS-1:0]          win_rd,
    input  wire logic signed [lmsf_pkg::WEIGHT_W-1:0]   wt_rd,
    output logic                                        wb_we,
    output logic [$clog2(MAX_TAPS)-1:0]                 wb_addr,
    output logic signed [lmsf_pkg::WEIGHT_W-1:0]        wb_data,
    output logic signed [SAMPLE_BITS-1:0]               filtered
);

    localparam int PTR_W   = $clog2(MAX_TAPS);
    localparam int CNT_W   = $clog2(MAX_TAPS + 1);
    localparam int W_W     = lmsf_pkg::WEIGHT_W;
    localparam int FRAC    = lmsf_pkg::WEIGHT_FRAC;
    localparam int MUL_A_W = (SAMPLE_BITS + 1 > W_W) ? SAMPLE_BITS + 1 : W_W;
    localparam int PROD_W  = MUL_A_W + SAMPLE_BITS;
    localparam int ACC_W   = PROD_W + CNT_W;

    localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
    localparam logic signed [W_W-1:0]         W_MAX = {1'b0, {(W_W - 1){1'b1}}};
    localparam logic signed [W_W-1:0]         W_MIN = {1'b1, {(W_W - 1){1'b0}}};

    lmsf_pkg::lmsf_op_t             op1_reg;
    lmsf_pkg::lmsf_op_t             op2_reg;
    logic [PTR_W-1:0]               q1_reg;
    logic [PTR_W-1:0]               q2_reg;
    logic signed [PROD_W-1:0]       mul_reg;
    logic signed [W_W-1:0]          w2_reg;
    logic signed [ACC_W-1:0]        acc_reg;
    logic signed [SAMPLE_BITS-1:0]  x_reg;
    logic signed [SAMPLE_BITS:0]    err_reg;
    logic signed [SAMPLE_BITS-1:0]  filt_reg;

    logic signed [MUL_A_W-1:0]      a_op;
    logic [ACC_W-FRAC-SAMPLE_BITS:0] acc_hi;
    logic signed [SAMPLE_BITS-1:0]  filt_sat;
    logic signed [SAMPLE_BITS:0]    err_calc;
    logic signed [PROD_W-1:0]       upd_d;
    logic signed [PROD_W:0]         upd_sum;
    logic [PROD_W-W_W+1:0]          sum_hi;

    // The window and weight reads arrive in the cycle after the request, so the
    // request tag is delayed by one stage to meet them.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op1_reg <= '0;
            op2_reg <= '0;
        end else begin
            op1_reg <= op;
            op2_reg <= op1_reg;
        end
    end

    always_comb begin
        a_op = op1_reg.upd ? MUL_A_W'(err_reg) : MUL_A_W'(wt_rd);
    end

    always_ff @(posedge aclk) begin
        q1_reg  <= op_tap;
        q2_reg  <= q1_reg;
        mul_reg <= PROD_W'(a_op) * PROD_W'(win_rd);
        w2_reg  <= wt_rd;
    end

    always_ff @(posedge aclk) begin
        if (ctl.clr_acc) begin
            acc_reg <= '0;
        end else if (op2_reg.issue && !op2_reg.upd) begin
            acc_reg <= acc_reg + ACC_W'(mul_reg);
        end
    end

    // Dropping the low fraction bits of the sum is a floor; the remaining
    // upper bits must all match the sign for the value to fit.
    always_comb begin
        acc_hi = acc_reg[ACC_W-1:FRAC+SAMPLE_BITS-1];
        if ((&acc_hi) || !(|acc_hi)) begin
            filt_sat = acc_reg[FRAC+SAMPLE_BITS-1:FRAC];
        end else begin
            filt_sat = acc_reg[ACC_W-1] ? S_MIN : S_MAX;
        end
        err_calc = (SAMPLE_BITS + 1)'(x_reg) - (SAMPLE_BITS + 1)'(filt_sat);
    end

    always_ff @(posedge aclk) begin
        if (ctl.clr_acc) begin
            x_reg <= sample;
        end
        if (ctl.latch_err) begin
            err_reg  <= err_calc;
            filt_reg <= filt_sat;
        end
    end

    always_comb begin
        upd_d   = mul_reg >>> step_shift;
        upd_sum = (PROD_W + 1)'(upd_d) + (PROD_W + 1)'(w2_reg);
        sum_hi  = upd_sum[PROD_W:W_W-1];
        if ((&sum_hi) || !(|sum_hi)) begin
            wb_data = upd_sum[W_W-1:0];
        end else begin
            wb_data = upd_sum[PROD_W] ? W_MIN : W_MAX;
        end
        wb_we   = op2_reg.issue && op2_reg.upd;
        wb_addr = q2_reg;
    end

    assign filtered = filt_reg;

endmodule

`default_nettype wire

// ----- rtl/core/lmsf_seq.sv -----
// ----------------------------------------------------------------------------
// lmsf_seq: tap sequencer
// Holds the trace counters and walks the taps twice per valid item: first
// for the filter sum, then for the weight update, with a drain wait for the
// multiplier pipeline after each walk.
// ----------------------------------------------------------------------------
`default_nettype none

module lmsf_seq #(
    parameter int MAX_TAPS = lmsf_pkg::MAX_TAPS_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               in_valid,
    input  wire logic                               in_last,
    input  wire logic [lmsf_pkg::TAP_CNT_W-1:0]     tap_count,
    input  wire logic                               out_free,
    output logic                                    in_ready,
    output lmsf_pkg::lmsf_store_ctl_t               store_ctl,
    output lmsf_pkg::lmsf_mac_ctl_t                 mac_ctl,
    output lmsf_pkg::lmsf_op_t                      op,
    output logic [$clog2(MAX_TAPS)-1:0]             win_waddr,
    output logic [$clog2(MAX_TAPS)-1:0]             rd_pos,
    output logic [$clog2(MAX_TAPS)-1:0]             rd_tap,
    output lmsf_pkg::lmsf_res_t                     res
);

    localparam int PTR_W = $clog2(MAX_TAPS);
    localparam int CNT_W = $clog2(MAX_TAPS + 1);
    localparam int TC_W  = lmsf_pkg::TAP_CNT_W + 1;

    localparam logic [TC_W-1:0]  MAX_TC   = TC_W'(MAX_TAPS);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(MAX_TAPS - 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MAC   = 3'd1;
    localparam logic [2:0] ST_MWAIT = 3'd2;
    localparam logic [2:0] ST_ERR   = 3'd3;
    localparam logic [2:0] ST_UPD   = 3'd4;
    localparam logic [2:0] ST_UWAIT = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    logic [2:0]       state_reg,  state_next;
    logic [PTR_W-1:0] wp_reg,     wp_next;
    logic [CNT_W-1:0] seen_reg,   seen_next;
    logic [PTR_W-1:0] nm1_reg,    nm1_next;
    logic [PTR_W-1:0] base_reg,   base_next;
    logic [PTR_W-1:0] q_reg,      q_next;
    logic [PTR_W-1:0] pos_reg,    pos_next;
    logic             drain_reg,  drain_next;
    logic             vld_reg,    vld_next;
    logic             last_reg,   last_next;

    logic [TC_W-1:0]  tc_ext;
    logic [TC_W-1:0]  n_tc;
    logic [TC_W-1:0]  b0_tc;
    logic [TC_W-1:0]  base_tc;
    logic             is_valid;
    logic             accept;
    logic [PTR_W-1:0] pos_inc;
    logic [PTR_W-1:0] wp_inc;

    // Taps in use: zero counts as one, anything above the window as the window.
    always_comb begin
        tc_ext = TC_W'(tap_count);
        if (tc_ext == '0) begin
            n_tc = TC_W'(1);
        end else if (tc_ext > MAX_TC) begin
            n_tc = MAX_TC;
        end else begin
            n_tc = tc_ext;
        end
        is_valid = TC_W'(seen_reg) >= n_tc;
        // Oldest sample of the window; the wrap-around sum stays below the
        // window size, so modular arithmetic in this width is exact.
        b0_tc = TC_W'(wp_reg) + TC_W'(1);
        if (b0_tc >= n_tc) begin
            base_tc = b0_tc - n_tc;
        end else begin
            base_tc = b0_tc - n_tc + MAX_TC;
        end
        pos_inc = (pos_reg == LAST_PTR) ? '0 : pos_reg + PTR_W'(1);
        wp_inc  = (wp_reg == LAST_PTR) ? '0 : wp_reg + PTR_W'(1);
    end

    assign accept = (state_reg == ST_IDLE) && in_valid;

    always_comb begin
        state_next = state_reg;
        wp_next    = wp_reg;
        seen_next  = seen_reg;
        nm1_next   = nm1_reg;
        base_next  = base_reg;
        q_next     = q_reg;
        pos_next   = pos_reg;
        drain_next = drain_reg;
        vld_next   = vld_reg;
        last_next  = last_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    nm1_next  = PTR_W'(n_tc - TC_W'(1));
                    base_next = PTR_W'(base_tc);
                    q_next    = '0;
                    pos_next  = PTR_W'(base_tc);
                    vld_next  = is_valid;
                    last_next = in_last;
                    if (in_last) begin
                        seen_next = '0;
                        wp_next   = '0;
                    end else begin
                        wp_next = wp_inc;
                        if (TC_W'(seen_reg) < n_tc) begin
                            seen_next = seen_reg + CNT_W'(1);
                        end
                    end
                    state_next = is_valid ? ST_MAC : ST_DONE;
                end
            end
            ST_MAC, ST_UPD: begin
                if (q_reg == nm1_reg) begin
                    drain_next = 1'b1;
                    state_next = (state_reg == ST_MAC) ? ST_MWAIT : ST_UWAIT;
                end else begin
                    q_next   = q_reg + PTR_W'(1);
                    pos_next = pos_inc;
                end
            end
            ST_MWAIT, ST_UWAIT: begin
                if (drain_reg) begin
                    drain_next = 1'b0;
                end else begin
                    state_next = (state_reg == ST_MWAIT) ? ST_ERR : ST_DONE;
                end
            end
            ST_ERR: begin
                q_next     = '0;
                pos_next   = base_reg;
                state_next = ST_UPD;
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            wp_reg    <= '0;
            seen_reg  <= '0;
        end else begin
            state_reg <= state_next;
            wp_reg    <= wp_next;
            seen_reg  <= seen_next;
        end
    end

    always_ff @(posedge aclk) begin
        nm1_reg   <= nm1_next;
        base_reg  <= base_next;
        q_reg     <= q_next;
        pos_reg   <= pos_next;
        drain_reg <= drain_next;
        vld_reg   <= vld_next;
        last_reg  <= last_next;
    end

    always_comb begin
        in_ready              = (state_reg == ST_IDLE);
        store_ctl.win_we      = accept;
        store_ctl.trace_start = accept && (seen_reg == '0);
        mac_ctl.clr_acc       = accept;
        mac_ctl.latch_err     = (state_reg == ST_ERR);
        op.issue              = (state_reg == ST_MAC) || (state_reg == ST_UPD);
        op.upd                = (state_reg == ST_UPD);
        win_waddr             = wp_reg;
        rd_pos                = pos_reg;
        rd_tap                = q_reg;
        res.done              = (state_reg == ST_DONE) && out_free;
        res.vld               = vld_reg;
        res.last              = last_reg;
    end

    a_tap_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        op.issue |-> (q_reg <= nm1_reg))
        else $error("tap request beyond the taps in use");

    a_upd_only_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_UPD) |-> vld_reg)
        else $error("weight update started for an item without a valid output");

endmodule

`default_nettype wire
